// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the indexed sequence store.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ISU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ISU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ISU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/isu_pkg.sv =====
// Package for the indexed sequence store: word types, operation and status codes.
// No dependencies; used by the stream interface users and the top level.
package isu_pkg;

    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    // Default number of elements held
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [CNT_OUT_W-1:0] t_cnt_out;

    // Request word
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_req;

    // Response word
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] read_value;
        t_cnt_out                count_after;
    } t_rsp;

endpackage

// ===== rtl/core/isu_stream_if.sv =====
// Valid/ready stream interface carrying one word of type T per handshake.
// No dependencies; the payload type is given where the interface is instantiated.
interface isu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/indexed_sequence_store_unit.sv =====
// Indexed sequence store: get, insert and delete by position over a single-port store.
// Depends on isu_pkg, isu_stream_if and assert_macros.svh.
//
//   channel  dir  word          handshake
//   i_req    in   isu_pkg::t_req  valid/ready, taken when both high
//   o_rsp    out  isu_pkg::t_rsp  valid/ready, taken when both high
//
// Sequence: a get goes through check and a store read, then the response handshake;
// a rejected request or unused code goes from check to the response; an insert or
// delete moves each element with one read and one write of the single store port,
// then a finish state updates the count before the handshake. One request in flight.
// Reset clears the count and sequencer; the store contents need no clearing.
// A stalled response holds the block until o_rsp.ready is seen.
`include "assert_macros.svh"

module indexed_sequence_store_unit #(
    parameter int CAPACITY = isu_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isu_stream_if.sink   i_req,
    isu_stream_if.source o_rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = (CW > isu_pkg::POS_W) ? CW : isu_pkg::POS_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_GET   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                       r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_idx, n_idx;
    logic [CW-1:0]                    r_lim, n_lim;
    logic                             r_dir, n_dir;       // 1 insert (move up), 0 delete
    logic [isu_pkg::OP_W-1:0]         r_op, n_op;
    logic [isu_pkg::POS_W-1:0]        r_pos, n_pos;
    logic signed [isu_pkg::VAL_W-1:0] r_val, n_val;
    logic [isu_pkg::STAT_W-1:0]       r_status, n_status;
    logic signed [isu_pkg::VAL_W-1:0] r_rd_value, n_rd_value;

    // Element store, one write and one registered read per cycle
    logic signed [isu_pkg::VAL_W-1:0] r_mem [CAPACITY];
    logic signed [isu_pkg::VAL_W-1:0] r_rdata;

    logic [CMPW-1:0]                  pos_x, cnt_x, ins_pos;
    logic [CW-1:0]                    step;
    logic                             mem_we, mem_re;
    logic [AW-1:0]                    mem_raddr;
    logic signed [isu_pkg::VAL_W-1:0] mem_wdata;

    assign pos_x = CMPW'(r_pos);
    assign cnt_x = CMPW'(r_count);

    // Shared index unit: one step up or down
    assign step = r_dir ? (r_idx - CW'(1)) : (r_idx + CW'(1));

    // Target place of an insert
    always_comb begin
        case (r_op)
            isu_pkg::OP_INS_HEAD: ins_pos = '0;
            isu_pkg::OP_INS_TAIL: ins_pos = cnt_x;
            default:              ins_pos = pos_x;
        endcase
    end

    // Store port control
    assign mem_we    = (r_state == S_WR) || ((r_state == S_FIN) && r_dir);
    assign mem_wdata = (r_state == S_WR) ? r_rdata : r_val;
    assign mem_re    = (r_state == S_RD)
                    || ((r_state == S_CHECK) && (r_op == isu_pkg::OP_GET) && (pos_x < cnt_x));
    assign mem_raddr = (r_state == S_RD) ? step[AW-1:0] : pos_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_dir      = r_dir;
        n_op       = r_op;
        n_pos      = r_pos;
        n_val      = r_val;
        n_status   = r_status;
        n_rd_value = r_rd_value;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.data.op;
                    n_pos   = i_req.data.position;
                    n_val   = i_req.data.item_value;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_status   = isu_pkg::ST_DONE;
                n_rd_value = '1;
                n_state    = S_OUT;
                case (r_op)
                    isu_pkg::OP_GET: begin
                        if (pos_x < cnt_x) begin
                            n_state = S_GET;
                        end else begin
                            n_status = isu_pkg::ST_RANGE;
                        end
                    end
                    isu_pkg::OP_INS_HEAD, isu_pkg::OP_INS_TAIL, isu_pkg::OP_INS_AT: begin
                        if (ins_pos > cnt_x) begin
                            n_status = isu_pkg::ST_RANGE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = isu_pkg::ST_FULL;
                        end else begin
                            n_dir   = 1'b1;
                            n_idx   = r_count;
                            n_lim   = CW'(ins_pos);
                            n_state = (ins_pos == cnt_x) ? S_FIN : S_RD;
                        end
                    end
                    isu_pkg::OP_DEL: begin
                        if (pos_x < cnt_x) begin
                            n_dir   = 1'b0;
                            n_idx   = CW'(pos_x);
                            n_lim   = r_count - CW'(1);
                            n_state = (CW'(pos_x) == (r_count - CW'(1))) ? S_FIN : S_RD;
                        end else begin
                            n_status = isu_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_GET: begin
                n_rd_value = r_rdata;
                n_state    = S_OUT;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                n_idx   = step;
                n_state = (step == r_lim) ? S_FIN : S_RD;
            end
            S_FIN: begin
                n_count = r_dir ? (r_count + CW'(1)) : (r_count - CW'(1));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_dir      <= n_dir;
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_status   <= n_status;
        r_rd_value <= n_rd_value;
    end

    // Ports
    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = (r_state == S_OUT);
    assign o_rsp.data.status      = r_status;
    assign o_rsp.data.read_value  = r_rd_value;
    assign o_rsp.data.count_after = isu_pkg::t_cnt_out'(r_count);

    // Checks
    `ISU_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `ISU_ASSERT_IMPL(a_ins_not_full, i_clk, i_rst_n, (r_state == S_FIN) && r_dir, r_count < CW'(CAPACITY), "insert completes on a full store")
    `ISU_ASSERT_IMPL(a_move_open, i_clk, i_rst_n, r_state == S_WR, r_idx != r_lim, "element move past its limit")
    `ISU_ASSERT_NEXT(a_rsp_release, i_clk, i_rst_n, o_rsp.valid && o_rsp.ready, i_req.ready && !o_rsp.valid, "sequencer not idle after response")

endmodule

// ===== tb/sv/indexed_sequence_store_unit_tb.sv =====
// Self-checking testbench for indexed_sequence_store_unit: directed corner requests, then
// random insert, delete and get traffic under varying backpressure, checked against a shadow.
// Depends on isu_pkg, isu_stream_if and the RTL of indexed_sequence_store_unit.
module indexed_sequence_store_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = isu_pkg::CAPACITY_DEF;

    // Operation codes the block leaves unused
    localparam logic [isu_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [isu_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [isu_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} t_mix;

    // Shadow of the sequence plus the queue of responses still owed
    class seq_scoreboard;
        logic signed [isu_pkg::VAL_W-1:0] shadow_elems [CAPACITY];
        int   shadow_count;
        isu_pkg::t_rsp owed_rsp [$];
        int   mismatches;
        int   checked;
        int   n_done;
        int   n_range;
        int   n_full;
        int   peak_count;

        function new();
            shadow_count = 0;
            mismatches   = 0;
            checked      = 0;
            n_done       = 0;
            n_range      = 0;
            n_full       = 0;
            peak_count   = 0;
        endfunction

        // Range check first, then the full check; later elements move up one place
        function logic [isu_pkg::STAT_W-1:0] insert_word(int pos,
                                                         logic signed [isu_pkg::VAL_W-1:0] val);
            if (pos > shadow_count) return isu_pkg::ST_RANGE;
            if (shadow_count >= CAPACITY) return isu_pkg::ST_FULL;
            for (int k = shadow_count; k > pos; k--) shadow_elems[k] = shadow_elems[k-1];
            shadow_elems[pos] = val;
            shadow_count++;
            return isu_pkg::ST_DONE;
        endfunction

        // Work out the response owed for an accepted request word
        function void note_request(isu_pkg::t_req r);
            isu_pkg::t_rsp want;
            int   pos;
            pos             = int'(r.position);
            want.status     = isu_pkg::ST_DONE;
            want.read_value = -1;
            case (r.op)
                isu_pkg::OP_GET: begin
                    if (pos < shadow_count) want.read_value = shadow_elems[pos];
                    else want.status = isu_pkg::ST_RANGE;
                end
                isu_pkg::OP_INS_HEAD: want.status = insert_word(0, r.item_value);
                isu_pkg::OP_INS_TAIL: want.status = insert_word(shadow_count, r.item_value);
                isu_pkg::OP_INS_AT:   want.status = insert_word(pos, r.item_value);
                isu_pkg::OP_DEL: begin
                    if (pos < shadow_count) begin
                        for (int k = pos; k < shadow_count - 1; k++)
                            shadow_elems[k] = shadow_elems[k+1];
                        shadow_count--;
                    end else begin
                        want.status = isu_pkg::ST_RANGE;
                    end
                end
                default: ;
            endcase
            want.count_after = isu_pkg::t_cnt_out'(shadow_count);
            if (want.status == isu_pkg::ST_DONE) n_done++;
            else if (want.status == isu_pkg::ST_RANGE) n_range++;
            else n_full++;
            if (shadow_count > peak_count) peak_count = shadow_count;
            owed_rsp.push_back(want);
        endfunction

        // Compare a response word with the oldest one owed
        function void check_response(isu_pkg::t_rsp got);
            isu_pkg::t_rsp want;
            if (owed_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response: status %0d read %0d count %0d",
                         $time, got.status, got.read_value, got.count_after);
                return;
            end
            want = owed_rsp.pop_front();
            checked++;
            if (got.status !== want.status) begin
                mismatches++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.read_value !== want.read_value) begin
                mismatches++;
                $display("%0t: read_value mismatch: expected %0d actual %0d",
                         $time, want.read_value, got.read_value);
            end
            if (got.count_after !== want.count_after) begin
                mismatches++;
                $display("%0t: count_after mismatch: expected %0d actual %0d",
                         $time, want.count_after, got.count_after);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    isu_stream_if #(.T(isu_pkg::t_req)) req_if ();
    isu_stream_if #(.T(isu_pkg::t_rsp)) rsp_if ();

    indexed_sequence_store_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    seq_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Response side: ready changes on the falling edge, long hold-off counted here
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0 && !hold_taken) begin
                hold_left  = hold_request;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Response words taken at the rising edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
        end
    end

    // Offer one request word, entered and left at a falling edge
    task automatic send_request(input logic [isu_pkg::OP_W-1:0] op,
                                input logic [isu_pkg::POS_W-1:0] pos,
                                input logic signed [isu_pkg::VAL_W-1:0] val);
        isu_pkg::t_req r;
        r.op         = op;
        r.position   = pos;
        r.item_value = val;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    // Hold the request side until every owed response has come back
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (sb.owed_rsp.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One random request, weighted by the mix; positions mostly legal for the current count
    task automatic send_random(input t_mix mix);
        logic [isu_pkg::OP_W-1:0]         op;
        logic [isu_pkg::POS_W-1:0]        pos;
        logic signed [isu_pkg::VAL_W-1:0] val;
        int cnt, roll, ins_share, del_share;
        cnt = sb.shadow_count;
        case (mix)
            MIX_GROW:   begin ins_share = 75; del_share = 10; end
            MIX_SHRINK: begin ins_share = 15; del_share = 65; end
            default:    begin ins_share = 40; del_share = 35; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_share) begin
            case ($urandom_range(0, 2))
                0:       op = isu_pkg::OP_INS_HEAD;
                1:       op = isu_pkg::OP_INS_TAIL;
                default: op = isu_pkg::OP_INS_AT;
            endcase
        end else if (roll < ins_share + del_share) begin
            op = isu_pkg::OP_DEL;
        end else begin
            op = isu_pkg::OP_GET;
        end
        if (op == isu_pkg::OP_INS_AT) pos = isu_pkg::POS_W'($urandom_range(0, cnt));
        else if (cnt > 0) pos = isu_pkg::POS_W'($urandom_range(0, cnt - 1));
        else pos = '0;
        // occasional position past the end
        if ($urandom_range(0, 9) == 0) pos = isu_pkg::POS_W'($urandom_range(cnt, 127));
        case ($urandom_range(0, 9))
            0:       val = 32'sh7fff_ffff;
            1:       val = 32'sh8000_0000;
            2:       val = '0;
            3:       val = -1;
            default: val = $urandom;
        endcase
        // noise: any code, any position
        if ($urandom_range(0, 99) < 5) begin
            op  = isu_pkg::OP_W'($urandom_range(0, 7));
            pos = isu_pkg::POS_W'($urandom_range(0, 127));
        end
        send_request(op, pos, val);
    endtask

    // Fill towards full, churn, then drain towards empty
    task automatic run_phase();
        repeat (120) send_random(MIX_GROW);
        repeat (80)  send_random(MIX_BALANCED);
        repeat (110) send_random(MIX_SHRINK);
    endtask

    // Run limit
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty store, ends and middle, past-the-end positions, unused codes
        send_request(isu_pkg::OP_GET,      7'd0,   32'sd5);
        send_request(isu_pkg::OP_DEL,      7'd0,   32'sd5);
        send_request(isu_pkg::OP_INS_AT,   7'd1,   32'sd7);
        send_request(isu_pkg::OP_INS_AT,   7'd0,   32'sh7fff_ffff);
        send_request(isu_pkg::OP_INS_HEAD, 7'd127, 32'sh8000_0000);
        send_request(isu_pkg::OP_INS_TAIL, 7'd127, 32'sd0);
        send_request(isu_pkg::OP_INS_AT,   7'd3,   -32'sd1);
        send_request(isu_pkg::OP_INS_AT,   7'd2,   32'sh1234_5678);
        send_request(isu_pkg::OP_GET,      7'd0,   32'sd0);
        send_request(isu_pkg::OP_GET,      7'd4,   32'sd0);
        send_request(isu_pkg::OP_GET,      7'd5,   32'sd0);
        send_request(isu_pkg::OP_GET,      7'd127, 32'sd0);
        send_request(isu_pkg::OP_INS_AT,   7'd127, 32'sd9);
        send_request(isu_pkg::OP_INS_AT,   7'd6,   32'sd9);
        send_request(isu_pkg::OP_DEL,      7'd127, 32'sd0);
        send_request(isu_pkg::OP_DEL,      7'd5,   32'sd0);
        send_request(isu_pkg::OP_DEL,      7'd2,   32'sd0);
        send_request(isu_pkg::OP_DEL,      7'd0,   32'sd0);
        send_request(isu_pkg::OP_DEL,      7'd2,   32'sd0);
        send_request(OP_SPARE_A,           7'd127, 32'sh7fff_ffff);
        send_request(OP_SPARE_B,           7'd0,   32'sh8000_0000);
        send_request(OP_SPARE_C,           7'd64,  -32'sd1);
        send_request(isu_pkg::OP_GET,      7'd1,   32'sd0);
        wait_drained();

        // Sender mostly offering, receiver mostly stalling
        send_idle_pct = 22;
        recv_idle_pct = 68;
        run_phase();
        wait_drained();

        // Sender mostly idle, receiver mostly ready; long hold-off on the response side first
        send_idle_pct = 68;
        recv_idle_pct = 22;
        hold_request  = 250;
        run_phase();
        wait_drained();

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase();
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d responses: %0d done, %0d out of range, %0d store full.",
                 sb.checked, sb.n_done, sb.n_range, sb.n_full);
        $display("Peak element count %0d of %0d, three backpressure mixes plus a long stall.",
                 sb.peak_count, CAPACITY);
        if (sb.mismatches == 0 && sb.owed_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/isu_pkg.sv
rtl/core/isu_stream_if.sv
rtl/core/indexed_sequence_store_unit.sv
tb/sv/indexed_sequence_store_unit_tb.sv
